// ===== hw/rtl/segment_rect_intersection_macros.svh =====
// ---------------------------------------------------------------------------
// segment_rect_intersection assertion macros
// Concurrent check wrappers, clocked on clk and disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef SEGMENT_RECT_INTERSECTION_MACROS_SVH
`define SEGMENT_RECT_INTERSECTION_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define SRI_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define SRI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SRI_ASSERT_NOW(lbl, ante, cons, msg)
`define SRI_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/sri_pkg.sv =====
// ---------------------------------------------------------------------------
// sri_pkg
// Shared types and helpers for the segment / rectangle hit test.
// ---------------------------------------------------------------------------
`default_nettype none

package sri_pkg;

	// sign of a cross product; both low means zero
	typedef struct packed {
		logic neg;
		logic pos;
	} sgn_t;

	// rectangle corner slots
	localparam int unsigned NUM_CORNERS = 4;
	localparam logic [1:0] CRN_TL = 2'd0;
	localparam logic [1:0] CRN_TR = 2'd1;
	localparam logic [1:0] CRN_BL = 2'd2;
	localparam logic [1:0] CRN_BR = 2'd3;

	// strictly opposite, nonzero signs
	function automatic logic opposite(sgn_t a, sgn_t b);
		return (a.pos && b.neg) || (a.neg && b.pos);
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/segment_rect_intersection.sv =====
// An accepted input word moves through the input, product and result registers in turn;
// its hit word is on the output while the result register holds it.
// Throughput: one word per cycle while no hit word is held; three pipeline registers.
// A held hit word freezes the whole pipe: in_stall is high while out_valid and out_stall are.
// Reset clears the valid bits only; payload registers are not reset.
// ---------------------------------------------------------------------------
// segment_rect_intersection
// Segment versus closed axis-aligned rectangle hit test, fully pipelined.
// ---------------------------------------------------------------------------
`default_nettype none

`include "segment_rect_intersection_macros.svh"

module segment_rect_intersection #(
	parameter int unsigned COORD_WIDTH = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,

	input  wire logic                          in_valid,
	output      logic                          in_stall,
	input  wire logic signed [COORD_WIDTH-1:0] start_x,
	input  wire logic signed [COORD_WIDTH-1:0] start_y,
	input  wire logic signed [COORD_WIDTH-1:0] end_x,
	input  wire logic signed [COORD_WIDTH-1:0] end_y,
	input  wire logic signed [COORD_WIDTH-1:0] box_x,
	input  wire logic signed [COORD_WIDTH-1:0] box_y,
	input  wire logic [COORD_WIDTH-2:0]        box_width,
	input  wire logic [COORD_WIDTH-2:0]        box_height,

	output      logic                          out_valid,
	input  wire logic                          out_stall,
	output      logic                          hit
);

	localparam int unsigned W  = COORD_WIDTH;
	localparam int unsigned RW = W + 2;        // corner minus endpoint
	localparam int unsigned PW = 2*W + 3;      // one product term

	// the pipe moves as a whole unless the result word is held
	logic advance;
	assign advance  = !(out_valid && out_stall);
	assign in_stall = !advance;

	// ---------------- stage 1: input register ----------------
	logic                valid_s1;
	logic signed [W-1:0] px_s1, py_s1, qx_s1, qy_s1, x0_s1, y0_s1;
	logic [W-2:0]        bw_s1, bh_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			px_s1 <= start_x;
			py_s1 <= start_y;
			qx_s1 <= end_x;
			qy_s1 <= end_y;
			x0_s1 <= box_x;
			y0_s1 <= box_y;
			bw_s1 <= box_width;
			bh_s1 <= box_height;
		end
	end

	// ---------------- stage 1 logic: corners, boxes, products ----------------
	// strict straddle of a level c by the pair (a, b)
	function automatic logic straddle(logic signed [W:0] a, logic signed [W:0] b,
		logic signed [W:0] c);
		return (a < c && b > c) || (a > c && b < c);
	endfunction

	logic signed [W:0]   px_e, py_e, qx_e, qy_e, x0_e, y0_e, x1_c, y1_c;
	logic signed [W-1:0] mnx, mxx, mny, mxy;
	logic signed [W:0]   dx_c, dy_c;
	logic                miss_c, inside_c, top_c, bot_c, left_c, right_c;
	logic signed [W:0]   cx [sri_pkg::NUM_CORNERS];
	logic signed [W:0]   cy [sri_pkg::NUM_CORNERS];
	logic signed [RW-1:0] rx [sri_pkg::NUM_CORNERS];
	logic signed [RW-1:0] ry [sri_pkg::NUM_CORNERS];
	logic signed [PW-1:0] pa_c [sri_pkg::NUM_CORNERS];
	logic signed [PW-1:0] pb_c [sri_pkg::NUM_CORNERS];

	assign px_e = (W+1)'(px_s1);
	assign py_e = (W+1)'(py_s1);
	assign qx_e = (W+1)'(qx_s1);
	assign qy_e = (W+1)'(qy_s1);
	assign x0_e = (W+1)'(x0_s1);
	assign y0_e = (W+1)'(y0_s1);
	// far corner never wraps: one extra bit
	assign x1_c = x0_e + $signed({2'b00, bw_s1});
	assign y1_c = y0_e + $signed({2'b00, bh_s1});

	assign mnx = (px_s1 < qx_s1) ? px_s1 : qx_s1;
	assign mxx = (px_s1 < qx_s1) ? qx_s1 : px_s1;
	assign mny = (py_s1 < qy_s1) ? py_s1 : qy_s1;
	assign mxy = (py_s1 < qy_s1) ? qy_s1 : py_s1;

	// bounding boxes apart
	assign miss_c = ((W+1)'(mxx) < x0_e) || ((W+1)'(mnx) > x1_c) ||
	                ((W+1)'(mxy) < y0_e) || ((W+1)'(mny) > y1_c);

	// either endpoint in the closed rectangle
	assign inside_c = (px_e >= x0_e && px_e <= x1_c && py_e >= y0_e && py_e <= y1_c) ||
	                  (qx_e >= x0_e && qx_e <= x1_c && qy_e >= y0_e && qy_e <= y1_c);

	// Side half of each proper-crossing test. A side's own cross products reduce
	// to side length times endpoint offset, so only signs matter; a zero-length
	// side never crosses.
	assign top_c   = (bw_s1 != '0) && straddle(py_e, qy_e, y0_e);
	assign bot_c   = (bw_s1 != '0) && straddle(py_e, qy_e, y1_c);
	assign left_c  = (bh_s1 != '0) && straddle(px_e, qx_e, x0_e);
	assign right_c = (bh_s1 != '0) && straddle(px_e, qx_e, x1_c);

	// segment direction
	assign dx_c = qx_e - px_e;
	assign dy_c = qy_e - py_e;

	assign cx[sri_pkg::CRN_TL] = x0_e;
	assign cy[sri_pkg::CRN_TL] = y0_e;
	assign cx[sri_pkg::CRN_TR] = x1_c;
	assign cy[sri_pkg::CRN_TR] = y0_e;
	assign cx[sri_pkg::CRN_BL] = x0_e;
	assign cy[sri_pkg::CRN_BL] = y1_c;
	assign cx[sri_pkg::CRN_BR] = x1_c;
	assign cy[sri_pkg::CRN_BR] = y1_c;

	// segment half: cross of (q-p) with (corner-p), one unit per corner
	for (genvar i = 0; i < sri_pkg::NUM_CORNERS; i++) begin : g_corner
		assign rx[i] = RW'(cx[i]) - RW'(px_s1);
		assign ry[i] = RW'(cy[i]) - RW'(py_s1);

		sri_corner_prod #(
			.W (W)
		) u_prod (
			.dx     (dx_c),
			.dy     (dy_c),
			.rx     (rx[i]),
			.ry     (ry[i]),
			.prod_a (pa_c[i]),
			.prod_b (pb_c[i])
		);
	end

	// ---------------- stage 2: product register ----------------
	logic                 valid_s2;
	logic                 miss_s2, inside_s2, top_s2, bot_s2, left_s2, right_s2;
	logic signed [PW-1:0] pa_s2 [sri_pkg::NUM_CORNERS];
	logic signed [PW-1:0] pb_s2 [sri_pkg::NUM_CORNERS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			miss_s2   <= miss_c;
			inside_s2 <= inside_c;
			top_s2    <= top_c;
			bot_s2    <= bot_c;
			left_s2   <= left_c;
			right_s2  <= right_c;
			pa_s2     <= pa_c;
			pb_s2     <= pb_c;
		end
	end

	// ---------------- stage 2 logic: signs and hit ----------------
	sri_pkg::sgn_t sg [sri_pkg::NUM_CORNERS];
	logic          hit_c;

	for (genvar i = 0; i < sri_pkg::NUM_CORNERS; i++) begin : g_sign
		sri_cross_sign #(
			.W (W)
		) u_sign (
			.prod_a (pa_s2[i]),
			.prod_b (pb_s2[i]),
			.sgn    (sg[i])
		);
	end

	assign hit_c = !miss_s2 && (inside_s2 ||
		(top_s2   && sri_pkg::opposite(sg[sri_pkg::CRN_TL], sg[sri_pkg::CRN_TR])) ||
		(bot_s2   && sri_pkg::opposite(sg[sri_pkg::CRN_BL], sg[sri_pkg::CRN_BR])) ||
		(left_s2  && sri_pkg::opposite(sg[sri_pkg::CRN_TL], sg[sri_pkg::CRN_BL])) ||
		(right_s2 && sri_pkg::opposite(sg[sri_pkg::CRN_TR], sg[sri_pkg::CRN_BR])));

	// ---------------- stage 3: result register ----------------
	logic valid_s3;
	logic hit_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (advance) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			hit_s3 <= hit_c;
		end
	end

	assign out_valid = valid_s3;
	assign hit       = hit_s3;

	// ---------------- checks ----------------
	`SRI_ASSERT_NEXT(a_fill, valid_s1 && advance, valid_s2, "stage 2 lost a word")
	`SRI_ASSERT_NOW(a_miss, valid_s2 && miss_s2, !hit_c, "hit with disjoint boxes")
	`SRI_ASSERT_NEXT(a_inside, valid_s2 && inside_s2 && !miss_s2 && advance, hit_s3,
		"endpoint inside but no hit")

endmodule

`default_nettype wire

// ===== hw/rtl/sri_corner_prod.sv =====
// ---------------------------------------------------------------------------
// sri_corner_prod
// Two products of the segment cross test against one rectangle corner.
// ---------------------------------------------------------------------------
`default_nettype none

module sri_corner_prod #(
	parameter int unsigned W = 16
) (
	input  wire logic signed [W:0]       dx,
	input  wire logic signed [W:0]       dy,
	input  wire logic signed [W+1:0]     rx,
	input  wire logic signed [W+1:0]     ry,
	output      logic signed [2*W+2:0]   prod_a,
	output      logic signed [2*W+2:0]   prod_b
);

	localparam int unsigned PW = 2*W + 3;

	// (q-p).x * (c-p).y and (q-p).y * (c-p).x
	assign prod_a = PW'(dx) * PW'(ry);
	assign prod_b = PW'(dy) * PW'(rx);

endmodule

`default_nettype wire

// ===== hw/rtl/sri_cross_sign.sv =====
// ---------------------------------------------------------------------------
// sri_cross_sign
// Sign of the difference of two registered products.
// ---------------------------------------------------------------------------
`default_nettype none

module sri_cross_sign #(
	parameter int unsigned W = 16
) (
	input  wire logic signed [2*W+2:0] prod_a,
	input  wire logic signed [2*W+2:0] prod_b,
	output      sri_pkg::sgn_t         sgn
);

	localparam int unsigned DW = 2*W + 4;

	logic signed [DW-1:0] diff;

	assign diff    = DW'(prod_a) - DW'(prod_b);
	assign sgn.neg = diff[DW-1];
	assign sgn.pos = !diff[DW-1] && (diff != '0);

endmodule

`default_nettype wire

// ===== bench/segment_rect_intersection_tb.sv =====
// ---------------------------------------------------------------------------
// segment_rect_intersection_tb
// Self-checking bench for the segment / rectangle hit test. Segment and box
// words go in over valid/stall, and the hit words are taken out under random
// and long output stalls. Each hit is checked in order against an integer
// predictor of the hit test that keeps its own wide arithmetic.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module segment_rect_intersection_tb;

	localparam int unsigned CW = 16;
	localparam int RESET_CYCLES = 8;
	localparam int PIPE_DEPTH = 3;       // input word to hit word, per the block header
	localparam int IDLE_LIMIT = 5000;    // cycles without any transfer before giving up
	localparam int HOLD_LEN = 80;        // long output hold-off, well past the pipe depth
	localparam int COORD_MIN = -32768;
	localparam int COORD_MAX = 32767;
	localparam int SIZE_MAX = 32767;
	localparam int MAX_REPORTS = 40;

	// families of random words
	typedef enum {
		SHAPE_NOISE,       // every field uniform over its range
		SHAPE_NEAR,        // small box, endpoints scattered around it
		SHAPE_THROUGH,     // endpoints on opposite sides, outside the box
		SHAPE_DEGENERATE,  // flat box, point box or zero-length segment
		SHAPE_GRAZE,       // along a side or through a corner
		SHAPE_EXTREME      // coordinates and sizes from the range limits and around zero
	} shape_t;

	typedef struct {
		logic        hit;
		int unsigned word_no;
	} hit_entry_t;

	logic clk;
	logic arst_n = 1'b0;

	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic signed [CW-1:0] start_x = '0;
	logic signed [CW-1:0] start_y = '0;
	logic signed [CW-1:0] end_x = '0;
	logic signed [CW-1:0] end_y = '0;
	logic signed [CW-1:0] box_x = '0;
	logic signed [CW-1:0] box_y = '0;
	logic [CW-2:0]        box_width = '0;
	logic [CW-2:0]        box_height = '0;

	logic out_valid;
	logic out_stall = 1'b0;
	logic hit;

	// predicted hits, oldest first
	hit_entry_t  pending_hits[$];
	int unsigned words_in = 0;
	int unsigned words_out = 0;
	int unsigned error_count = 0;

	// idling knobs; set only at the falling edge (the receiver clears hold_request)
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	bit          hold_request = 1'b0;

	segment_rect_intersection #(
		.COORD_WIDTH(CW)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.start_x    (start_x),
		.start_y    (start_y),
		.end_x      (end_x),
		.end_y      (end_y),
		.box_x      (box_x),
		.box_y      (box_y),
		.box_width  (box_width),
		.box_height (box_height),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.hit        (hit)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// -----------------------------------------------------------------------
	// Hit predictor. Everything is carried in 64-bit signed values: corners
	// reach 17 bits, cross products about 37, so nothing can wrap.
	// -----------------------------------------------------------------------

	// sign of (a - o) x (b - o)
	function automatic int cross_sign(input longint ox, input longint oy,
			input longint ax, input longint ay, input longint bx, input longint by);
		longint c;
		c = (ax - ox) * (by - oy) - (ay - oy) * (bx - ox);
		return (c > 0) ? 1 : ((c < 0) ? -1 : 0);
	endfunction

	// strict crossing of segment p-q with side a-b; touching or collinear is no crossing
	function automatic bit crosses_side(input longint px, input longint py,
			input longint qx, input longint qy, input longint ax, input longint ay,
			input longint bx, input longint by);
		int d1, d2, d3, d4;
		d1 = cross_sign(ax, ay, bx, by, px, py);
		d2 = cross_sign(ax, ay, bx, by, qx, qy);
		d3 = cross_sign(px, py, qx, qy, ax, ay);
		d4 = cross_sign(px, py, qx, qy, bx, by);
		return (d1 * d2 < 0) && (d3 * d4 < 0);
	endfunction

	function automatic logic predict_hit(input logic signed [CW-1:0] sx,
			input logic signed [CW-1:0] sy, input logic signed [CW-1:0] ex,
			input logic signed [CW-1:0] ey, input logic signed [CW-1:0] bx,
			input logic signed [CW-1:0] by, input logic [CW-2:0] bw,
			input logic [CW-2:0] bh);
		longint px, py, qx, qy, x0, y0, x1, y1;
		bit     p_in, q_in;
		px = sx;
		py = sy;
		qx = ex;
		qy = ey;
		x0 = bx;
		y0 = by;
		x1 = x0 + longint'(bw);
		y1 = y0 + longint'(bh);
		// bounding boxes apart: no hit
		if ((px > qx ? px : qx) < x0 || (px < qx ? px : qx) > x1 ||
				(py > qy ? py : qy) < y0 || (py < qy ? py : qy) > y1)
			return 1'b0;
		// an endpoint in the closed box
		p_in = px >= x0 && px <= x1 && py >= y0 && py <= y1;
		q_in = qx >= x0 && qx <= x1 && qy >= y0 && qy <= y1;
		if (p_in || q_in)
			return 1'b1;
		// top, bottom, left, right
		return crosses_side(px, py, qx, qy, x0, y0, x1, y0) ||
			crosses_side(px, py, qx, qy, x0, y1, x1, y1) ||
			crosses_side(px, py, qx, qy, x0, y0, x0, y1) ||
			crosses_side(px, py, qx, qy, x1, y0, x1, y1);
	endfunction

	task automatic report_mismatch(input string msg);
		error_count++;
		if (error_count <= MAX_REPORTS)
			$display("%0t ERROR: %s", $time, msg);
	endtask

	// -----------------------------------------------------------------------
	// Scoreboard. Both channels are sampled at the rising edge, where the
	// values seen are those from before the edge. The output side is
	// checked before the input side is recorded; with a pipe of three
	// stages the word leaving can never be the word entering.
	// -----------------------------------------------------------------------
	always @(posedge clk) begin : scoreboard
		hit_entry_t oldest;
		hit_entry_t incoming;
		if (out_valid && !out_stall) begin
			if (pending_hits.size() == 0) begin
				report_mismatch($sformatf("hit word %0d arrived with none outstanding",
					words_out));
			end else begin
				oldest = pending_hits.pop_front();
				if (hit !== oldest.hit)
					report_mismatch($sformatf("word %0d: hit %b, predicted %b",
						oldest.word_no, hit, oldest.hit));
			end
			words_out++;
		end
		if (in_valid && !in_stall) begin
			incoming.hit = predict_hit(start_x, start_y, end_x, end_y,
				box_x, box_y, box_width, box_height);
			incoming.word_no = words_in;
			pending_hits = {pending_hits, incoming};
			words_in++;
		end
	end

	// -----------------------------------------------------------------------
	// Output side: random stalls, plus a long hold-off on request. The
	// request flag is raised at a falling edge and consumed here.
	// -----------------------------------------------------------------------
	initial begin : receiver
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_LEN;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	// hang detector: any accepted word on either side restarts the count
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t ERROR: no transfer for %0d cycles, %0d hits outstanding", $time,
			IDLE_LIMIT, pending_hits.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// -----------------------------------------------------------------------
	// Input side
	// -----------------------------------------------------------------------

	function automatic logic signed [CW-1:0] coord(input int v);
		if (v < COORD_MIN)
			v = COORD_MIN;
		if (v > COORD_MAX)
			v = COORD_MAX;
		return v[CW-1:0];
	endfunction

	function automatic logic [CW-2:0] extent(input int v);
		if (v < 0)
			v = 0;
		if (v > SIZE_MAX)
			v = SIZE_MAX;
		return v[CW-2:0];
	endfunction

	function automatic int rand_coord();
		return int'($urandom_range(65535)) - 32768;
	endfunction

	// Offers one word and returns at the edge that takes it. Valid stays up
	// into the next call, so it is never dropped and raised in one step.
	task automatic send_word(input logic signed [CW-1:0] sx, input logic signed [CW-1:0] sy,
			input logic signed [CW-1:0] ex, input logic signed [CW-1:0] ey,
			input logic signed [CW-1:0] bx, input logic signed [CW-1:0] by,
			input logic [CW-2:0] bw, input logic [CW-2:0] bh);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		start_x    <= sx;
		start_y    <= sy;
		end_x      <= ex;
		end_y      <= ey;
		box_x      <= bx;
		box_y      <= by;
		box_width  <= bw;
		box_height <= bh;
		do
			@(posedge clk);
		while (in_stall);
	endtask

	task automatic send_random_word();
		int          sx, sy, ex, ey, bx, by, bw, bh, cx, cy, d, d2, s, t, pick;
		int unsigned r;
		shape_t      shape;
		int          coord_set[7];
		int          size_set[4];
		coord_set = '{COORD_MIN, COORD_MIN + 1, -1, 0, 1, COORD_MAX - 1, COORD_MAX};
		size_set = '{0, 1, SIZE_MAX - 1, SIZE_MAX};
		r = $urandom_range(99);
		shape = (r < 15) ? SHAPE_NOISE : (r < 45) ? SHAPE_NEAR : (r < 65) ? SHAPE_THROUGH :
			(r < 75) ? SHAPE_DEGENERATE : (r < 88) ? SHAPE_GRAZE : SHAPE_EXTREME;
		// a small box anywhere on the plane, used by most shapes
		bx = rand_coord();
		by = rand_coord();
		bw = $urandom_range(200);
		bh = $urandom_range(200);
		sx = bx + int'($urandom_range(bw + 200)) - 100;
		sy = by + int'($urandom_range(bh + 200)) - 100;
		ex = bx + int'($urandom_range(bw + 200)) - 100;
		ey = by + int'($urandom_range(bh + 200)) - 100;
		case (shape)
			SHAPE_NOISE: begin
				sx = rand_coord();
				sy = rand_coord();
				ex = rand_coord();
				ey = rand_coord();
				bw = $urandom_range(SIZE_MAX);
				bh = $urandom_range(SIZE_MAX);
			end
			SHAPE_THROUGH: begin
				if ($urandom_range(1)) begin
					sx = bx - 1 - int'($urandom_range(500));
					ex = bx + bw + 1 + int'($urandom_range(500));
					sy = by - 200 + int'($urandom_range(bh + 400));
					ey = by - 200 + int'($urandom_range(bh + 400));
				end else begin
					sy = by - 1 - int'($urandom_range(500));
					ey = by + bh + 1 + int'($urandom_range(500));
					sx = bx - 200 + int'($urandom_range(bw + 400));
					ex = bx - 200 + int'($urandom_range(bw + 400));
				end
			end
			SHAPE_DEGENERATE: begin
				pick = $urandom_range(3);
				if (pick == 0 || pick == 2)
					bw = 0;
				if (pick == 1 || pick == 2)
					bh = 0;
				if (pick == 3) begin
					ex = sx;
					ey = sy;
				end
			end
			SHAPE_GRAZE: begin
				bw = $urandom_range(1, 200);
				bh = $urandom_range(1, 200);
				cx = bx + ($urandom_range(1) ? bw : 0);
				cy = by + ($urandom_range(1) ? bh : 0);
				d = $urandom_range(1, 300);
				d2 = $urandom_range(1, 300);
				pick = $urandom_range(2);
				if (pick == 0) begin
					// diagonal through a corner: grazes or cuts in, by direction
					s = $urandom_range(1) ? 1 : -1;
					sx = cx - d;
					sy = cy - s * d;
					ex = cx + d2;
					ey = cy + s * d2;
				end else if (pick == 1) begin
					// on the line of a horizontal side
					sx = bx - d;
					ex = bx + bw + d2;
					sy = cy;
					ey = cy;
				end else begin
					// on the line of a vertical side
					sy = by - d;
					ey = by + bh + d2;
					sx = cx;
					ex = cx;
				end
			end
			SHAPE_EXTREME: begin
				sx = coord_set[$urandom_range(6)];
				sy = coord_set[$urandom_range(6)];
				ex = coord_set[$urandom_range(6)];
				ey = coord_set[$urandom_range(6)];
				bx = coord_set[$urandom_range(6)];
				by = coord_set[$urandom_range(6)];
				bw = size_set[$urandom_range(3)];
				bh = size_set[$urandom_range(3)];
			end
			default: ;
		endcase
		if ($urandom_range(1)) begin
			t = sx;
			sx = ex;
			ex = t;
			t = sy;
			sy = ey;
			ey = t;
		end
		send_word(coord(sx), coord(sy), coord(ex), coord(ey), coord(bx), coord(by),
			extent(bw), extent(bh));
	endtask

	// Drops valid at the current edge, changes the idling mix at the falling
	// edge, and comes back on a rising edge ready to drive.
	task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
		in_valid <= 1'b0;
		@(negedge clk);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		@(posedge clk);
	endtask

	// waits for the last predicted hit; valid must already be low
	task automatic wait_drained();
		@(negedge clk);
		while (pending_hits.size() != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	// -----------------------------------------------------------------------
	// Tests
	// -----------------------------------------------------------------------

	// field extremes and the corner cases of the hit rules
	task automatic test_directed();
		set_idling(0, 0);
		// point segment on a point box at the origin
		send_word(0, 0, 0, 0, 0, 0, 0, 0);
		// everything at the negative limit
		send_word(-32768, -32768, -32768, -32768, -32768, -32768, 0, 0);
		// everything at the positive limit; far corner lies past the coordinate range
		send_word(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
		// full-range diagonal through a small box
		send_word(-32768, -32768, 32767, 32767, 0, 0, 10, 10);
		// full-range anti-diagonal against the largest box
		send_word(-32768, 32767, 32767, -32768, -32768, -32768, 32767, 32767);
		// widest box, just left of and above the segment's bounding box
		send_word(0, 0, 32767, 32767, -32768, -32768, 32767, 32767);
		// zero-width box crossed by a horizontal segment
		send_word(-10, 50, 10, 50, 0, 0, 0, 100);
		// zero-height box crossed by a vertical segment
		send_word(50, -10, 50, 10, 0, 0, 100, 0);
		// point box on the interior of the segment: no side to cross
		send_word(-5, -5, 5, 5, 0, 0, 0, 0);
		// collinear with the top side, overhanging both ends
		send_word(-10, 0, 110, 0, 0, 0, 100, 100);
		// collinear with the left side
		send_word(0, -10, 0, 110, 0, 0, 100, 100);
		// touches the top-left corner only
		send_word(-10, 10, 10, -10, 0, 0, 100, 100);
		// endpoint exactly on the bottom-right corner
		send_word(100, 100, 200, 300, 0, 0, 100, 100);
		// zero-length segment one step above the box
		send_word(50, -1, 50, -1, 0, 0, 100, 100);
		// zero-length segment inside
		send_word(50, 50, 50, 50, 0, 0, 100, 100);
		// bounding boxes overlap but the segment passes outside the corner
		send_word(-10, 5, 5, -10, 0, 0, 100, 100);
		// straight through, both endpoints outside
		send_word(50, -10, 50, 110, 0, 0, 100, 100);
		// long diagonal near a box at the far edge of the plane
		send_word(-32768, -32768, 32767, 32767, 32000, 30000, 1000, 1000);
		// line just below a box that ends at y = -1
		send_word(-32768, 0, 32767, 0, -32768, -32768, 32767, 32767);
		// alternating bit patterns on every field, both phases
		send_word(16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA,
			15'h2AAA, 15'h5555);
		send_word(16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555,
			15'h5555, 15'h2AAA);
	endtask

	task automatic test_random(input int count, input int unsigned send_pct,
			input int unsigned recv_pct);
		set_idling(send_pct, recv_pct);
		repeat (count) send_random_word();
	endtask

	// Output held off for a long stretch while words keep coming, so the
	// pipe fills and the input stall has to come up and hold.
	task automatic test_backpressure();
		set_idling(0, 20);
		@(negedge clk);
		hold_request = 1'b1;
		@(posedge clk);
		repeat (40) send_random_word();
	endtask

	// sender goes quiet until every hit is out, then resumes on an empty pipe
	task automatic test_drain_pause();
		in_valid <= 1'b0;
		wait_drained();
		repeat (30) send_random_word();
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_random(330, 18, 45);
		test_random(330, 45, 18);
		test_backpressure();
		test_drain_pause();
		test_random(330, 0, 0);

		// everything offered; let the pipe empty and give a late extra word time to show
		in_valid <= 1'b0;
		wait_drained();
		repeat (PIPE_DEPTH + 4) @(posedge clk);
		@(negedge clk);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
